[design/v4n_pkg.sv]
package v4n_pkg;

  localparam int COMP_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int SQ_W      = 2 * COMP_W;
  localparam int SUM_W     = SQ_W + 1;
  localparam int LEN_W     = COMP_W + 1;
  localparam int QUO_W     = FRAC_W + 1;
  localparam int SQRT_STG  = LEN_W;
  localparam int DIV_STG   = QUO_W;
  localparam int LANES     = 4;
  localparam int VEC_W     = LANES * COMP_W;

  function automatic logic [COMP_W-1:0] mag_of(input logic [COMP_W-1:0] raw);
    mag_of = raw[COMP_W-1] ? (~raw + COMP_W'(1)) : raw;
  endfunction

endpackage

[design/v4n_sq_lane.sv]
module v4n_sq_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic [v4n_pkg::COMP_W-1:0]       raw,
  output logic [v4n_pkg::SQ_W-1:0]         sq_r
);

  logic [v4n_pkg::COMP_W-1:0] mag;
  logic [v4n_pkg::SQ_W-1:0]   sq_nxt;

  assign mag    = v4n_pkg::mag_of(raw);
  assign sq_nxt = {{v4n_pkg::COMP_W{1'b0}}, mag} * {{v4n_pkg::COMP_W{1'b0}}, mag};

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

endmodule

[design/v4n_sqrt.sv]
module v4n_sqrt #(
  parameter int SIDE_W = v4n_pkg::VEC_W
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [v4n_pkg::SUM_W-1:0]    sum,
  input  logic [SIDE_W-1:0]            side_in,
  output logic [v4n_pkg::LEN_W-1:0]    root,
  output logic [SIDE_W-1:0]            side_out
);

  localparam int N = v4n_pkg::SQRT_STG;
  localparam int TW = v4n_pkg::SUM_W + 2;

  logic [v4n_pkg::SUM_W-1:0] rem_r  [N];
  logic [v4n_pkg::LEN_W-1:0] root_r [N];
  logic [SIDE_W-1:0]         side_r [N];

  // one result bit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_stg
    localparam int I = N - 1 - k;
    logic [v4n_pkg::SUM_W-1:0] rem_in;
    logic [v4n_pkg::LEN_W-1:0] root_in;
    logic [SIDE_W-1:0]         side_stg;
    logic [TW-1:0]             trial;
    logic                      ge;

    if (k == 0) begin : g_first
      assign rem_in   = sum;
      assign root_in  = '0;
      assign side_stg = side_in;
    end else begin : g_next
      assign rem_in   = rem_r[k-1];
      assign root_in  = root_r[k-1];
      assign side_stg = side_r[k-1];
    end

    assign trial = ({{(TW-v4n_pkg::LEN_W){1'b0}}, root_in} << (I + 1))
                 | (TW'(1) << (2 * I));
    assign ge    = {2'b00, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_in - trial[v4n_pkg::SUM_W-1:0] : rem_in;
        root_r[k] <= ge ? (root_in | (v4n_pkg::LEN_W'(1) << I)) : root_in;
        side_r[k] <= side_stg;
      end
    end
  end

  assign root     = root_r[N-1];
  assign side_out = side_r[N-1];

endmodule

[design/v4n_div_lane.sv]
module v4n_div_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic [v4n_pkg::COMP_W-1:0]   raw,
  input  logic [v4n_pkg::LEN_W-1:0]    len,
  output logic [v4n_pkg::COMP_W-1:0]   res,
  output logic [v4n_pkg::LEN_W-1:0]    len_out
);

  localparam int N  = v4n_pkg::DIV_STG;
  localparam int RW = v4n_pkg::COMP_W + v4n_pkg::FRAC_W;
  localparam int DW = RW + 2;

  logic [RW-1:0]                   rem_r [N];
  logic [v4n_pkg::QUO_W-1:0]       quo_r [N];
  logic [v4n_pkg::LEN_W-1:0]       len_r [N];
  logic [v4n_pkg::COMP_W-1:0]      raw_r [N];
  logic [v4n_pkg::COMP_W-1:0]      qx;

  for (genvar k = 0; k < N; k++) begin : g_stg
    localparam int J = N - 1 - k;
    logic [RW-1:0]                 rem_in;
    logic [v4n_pkg::QUO_W-1:0]     quo_in;
    logic [v4n_pkg::LEN_W-1:0]     len_in;
    logic [v4n_pkg::COMP_W-1:0]    raw_in;
    logic [DW-1:0]                 dsh;
    logic                          ge;

    if (k == 0) begin : g_first
      assign rem_in = {v4n_pkg::mag_of(raw), {v4n_pkg::FRAC_W{1'b0}}};
      assign quo_in = '0;
      assign len_in = len;
      assign raw_in = raw;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign len_in = len_r[k-1];
      assign raw_in = raw_r[k-1];
    end

    assign dsh = {{(DW-v4n_pkg::LEN_W){1'b0}}, len_in} << J;
    assign ge  = {2'b00, rem_in} >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? rem_in - dsh[RW-1:0] : rem_in;
        quo_r[k] <= ge ? (quo_in | (v4n_pkg::QUO_W'(1) << J)) : quo_in;
        len_r[k] <= len_in;
        raw_r[k] <= raw_in;
      end
    end
  end

  assign qx = {{(v4n_pkg::COMP_W-v4n_pkg::QUO_W){1'b0}}, quo_r[N-1]};

  // zero length passes the component through
  always_comb begin
    if (len_r[N-1] == '0) begin
      res = raw_r[N-1];
    end else if (raw_r[N-1][v4n_pkg::COMP_W-1]) begin
      res = ~qx + v4n_pkg::COMP_W'(1);
    end else begin
      res = qx;
    end
  end

  assign len_out = len_r[N-1];

endmodule

[design/vector4_normalize_unit.sv]
// vector4_normalize_unit: normalises one signed Q16.16 4-vector per beat
//
// in_tdata carries x, y, z, w; a beat is taken when in_tvalid and in_tready
// are both high. each input beat gives exactly one output beat with the
// unit vector, the floor square-root length and a zero-length flag.
// a zero vector comes out unchanged with the flag set.
//
// pipeline: one squaring stage, one adder stage, 33 square-root stages at
// one root bit each, 17 divider stages per lane at one quotient bit each,
// output register. throughput: one vector per cycle while the receiver
// does not stall; the four lanes each own a squarer and a divider, the
// square root is shared between them.
//
// when the receiver stalls, the output register holds its beat and the
// whole pipeline freezes; in_tready follows out_tready whenever a beat is
// waiting. bubbles do not close up.
// reset (synchronous rst_n low) clears all valid flags; no beat is in
// flight afterwards and out_tvalid is low.
module vector4_normalize_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [v4n_pkg::VEC_W-1:0]     in_tdata,  // in_x, in_y, in_z, in_w
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [167:0]                  out_tdata,  // out_x, out_y, out_z, out_w, vec_length, pad
  output logic                          out_tuser   // zero_length
);

  localparam int LANES  = v4n_pkg::LANES;
  localparam int CW     = v4n_pkg::COMP_W;
  localparam int LW     = v4n_pkg::LEN_W;
  localparam int VW     = LANES * CW;
  localparam int PIPE_N = 2 + v4n_pkg::SQRT_STG + v4n_pkg::DIV_STG;

  logic                    en;
  logic [PIPE_N-1:0]       vld_r;
  logic [v4n_pkg::SQ_W-1:0] sq_r [LANES];
  logic [VW-1:0]           raw1_r;
  logic [VW-1:0]           raw2_r;
  logic [v4n_pkg::SUM_W-1:0] sum_r;
  logic [v4n_pkg::SUM_W-1:0] sum_nxt;
  logic [LW-1:0]           len;
  logic [VW-1:0]           raw_s;
  logic [CW-1:0]           res   [LANES];
  logic [LW-1:0]           len_l [LANES];
  logic [VW-1:0]           res_v;
  logic                    out_vld_r;
  logic [VW-1:0]           out_vec_r;
  logic [LW-1:0]           out_len_r;
  logic                    out_zero_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  for (genvar l = 0; l < LANES; l++) begin : g_sq
    v4n_sq_lane u_sq (
      .clk  (clk),
      .en   (en),
      .raw  (in_tdata[l*CW +: CW]),
      .sq_r (sq_r[l])
    );
  end

  always_comb begin
    sum_nxt = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_nxt = sum_nxt + {1'b0, sq_r[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw1_r <= in_tdata;
      raw2_r <= raw1_r;
      sum_r  <= sum_nxt;
    end
  end

  v4n_sqrt #(.SIDE_W(VW)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .sum      (sum_r),
    .side_in  (raw2_r),
    .root     (len),
    .side_out (raw_s)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_div
    v4n_div_lane u_div (
      .clk     (clk),
      .en      (en),
      .raw     (raw_s[l*CW +: CW]),
      .len     (len),
      .res     (res[l]),
      .len_out (len_l[l])
    );
    assign res_v[l*CW +: CW] = res[l];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[PIPE_N-2:0], in_tvalid};
      out_vld_r <= vld_r[PIPE_N-1];
    end
  end

  // merge stage: lane results plus length from the first lane
  always_ff @(posedge clk) begin
    if (en) begin
      out_vec_r  <= res_v;
      out_len_r  <= len_l[0];
      out_zero_r <= (len_l[0] == '0);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(168-VW-LW){1'b0}}, out_len_r, out_vec_r};
  assign out_tuser  = out_zero_r;

endmodule

[bench/tb_vector4_normalize_unit.sv]
`timescale 1ns / 1ps

module tb_vector4_normalize_unit;

  typedef struct packed {
    logic [v4n_pkg::COMP_W-1:0] x, y, z, w;
  } vec_t;

  typedef struct packed {
    logic [v4n_pkg::COMP_W-1:0] x, y, z, w;
    logic [v4n_pkg::LEN_W-1:0]  len;
    logic                       zero;
  } norm_t;

  class norm_scoreboard;
    norm_t pending[$];
    int    errors;

    // floor square root of a 65-bit sum, one root bit per pass
    function logic [v4n_pkg::LEN_W-1:0] floor_root(input logic [v4n_pkg::SUM_W-1:0] s);
      logic [v4n_pkg::LEN_W-1:0] r;
      logic [v4n_pkg::SUM_W:0]   trial;
      r = '0;
      for (int b = v4n_pkg::LEN_W - 1; b >= 0; b--) begin
        trial = (v4n_pkg::SUM_W + 1)'(r | (v4n_pkg::LEN_W'(1) << b))
              * (v4n_pkg::SUM_W + 1)'(r | (v4n_pkg::LEN_W'(1) << b));
        if (trial <= {1'b0, s}) r = r | (v4n_pkg::LEN_W'(1) << b);
      end
      return r;
    endfunction

    function logic [v4n_pkg::COMP_W-1:0] unit_comp(input logic [v4n_pkg::COMP_W-1:0] c,
                                                   input logic [v4n_pkg::LEN_W-1:0] len);
      logic [v4n_pkg::COMP_W:0]                  m;
      logic [v4n_pkg::COMP_W+v4n_pkg::FRAC_W:0]  q;
      m = c[v4n_pkg::COMP_W-1] ? ({1'b0, ~c} + 1'b1) : {1'b0, c};
      q = ({m, {v4n_pkg::FRAC_W{1'b0}}}) / len;
      if (c[v4n_pkg::COMP_W-1]) q = ~q + 1'b1;
      return q[v4n_pkg::COMP_W-1:0];
    endfunction

    function void note_input(input vec_t v);
      logic [v4n_pkg::COMP_W-1:0] comp[4];
      logic [v4n_pkg::SUM_W-1:0]  sum;
      logic [v4n_pkg::COMP_W:0]   m;
      norm_t e;
      comp = '{v.x, v.y, v.z, v.w};
      sum = '0;
      foreach (comp[i]) begin
        m = comp[i][v4n_pkg::COMP_W-1] ? ({1'b0, ~comp[i]} + 1'b1) : {1'b0, comp[i]};
        sum = sum + v4n_pkg::SUM_W'(m) * v4n_pkg::SUM_W'(m);
      end
      e.len = floor_root(sum);
      e.zero = (e.len == 0);
      if (e.zero) begin
        {e.x, e.y, e.z, e.w} = {v.x, v.y, v.z, v.w};
      end else begin
        e.x = unit_comp(v.x, e.len);
        e.y = unit_comp(v.y, e.len);
        e.z = unit_comp(v.z, e.len);
        e.w = unit_comp(v.w, e.len);
      end
      pending.push_back(e);
    endfunction

    task report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_result(input logic [167:0] data, input logic user);
      norm_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", data[63:0], 0);
        return;
      end
      e = pending.pop_front();
      if (data[31:0] !== e.x) report("out_x", data[31:0], e.x);
      if (data[63:32] !== e.y) report("out_y", data[63:32], e.y);
      if (data[95:64] !== e.z) report("out_z", data[95:64], e.z);
      if (data[127:96] !== e.w) report("out_w", data[127:96], e.w);
      if (data[160:128] !== e.len) report("vec_length", data[160:128], e.len);
      if (user !== e.zero) report("zero_length", user, e.zero);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [v4n_pkg::VEC_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [167:0] out_tdata;
  logic out_tuser;

  norm_scoreboard board = new();
  int  idle_cycles = 0;

  always #5 clk = ~clk;

  vector4_normalize_unit dut (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [v4n_pkg::COMP_W-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 131072)) - 65536);
      3: return 32'(int'($urandom_range(0, 4)) - 2);
      default: return $urandom;
    endcase
  endfunction

  // in_tvalid stays high across back-to-back beats, dropped only for a gap
  task send_vec(input vec_t v);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {v.w, v.z, v.y, v.x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(v);
  endtask

  // receiver: random stalls, whole stretches without any
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
      out_tready <= (stall == 0);
      @(posedge clk);
      if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
      repeat (stall) @(posedge clk);
      if (stall != 0) begin
        out_tready <= 1;
        @(posedge clk);
        if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
      end
    end
  end

  // watchdog on cycles without a beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("FAIL vector4_normalize_unit");
      $finish;
    end
  end

  initial begin
    vec_t v;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: zero vector, all -2^31, extremes, single axes
    send_vec('{0, 0, 0, 0});
    send_vec('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_vec('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    send_vec('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
    send_vec('{32'h0001_0000, 0, 0, 0});
    send_vec('{0, 32'hffff_0000, 0, 0});
    send_vec('{0, 0, 32'h0000_0001, 0});
    send_vec('{0, 0, 0, 32'hffff_ffff});
    send_vec('{32'h8000_0000, 0, 0, 0});
    send_vec('{1, 1, 1, 1});
    send_vec('{32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001});
    send_vec('{32'h0003_0000, 32'h0004_0000, 0, 0});
    send_vec('{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa});
    // pause until the pipeline has drained
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < 1700; i++) begin
      if ($urandom_range(0, 40) == 0) v = '{0, 0, 0, 0};
      else v = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      send_vec(v);
      if (i == 850) begin
        in_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
      end
    end
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS vector4_normalize_unit");
    end else begin
      $display("FAIL vector4_normalize_unit");
    end
    $finish;
  end
endmodule
